>>> hw/rtl/vsf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vsf_pkg
// Shared types and constants for the value stack with frames.
// ----------------------------------------------------------------------------
package vsf_pkg;

    localparam int DEF_STACK_DEPTH = 2048;

    localparam int WORD_W   = 64;
    localparam int SLOT_W   = 11;
    localparam int FILL_W   = 12;
    localparam int LEVEL_W  = 12;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;

    // slave tdata: word_in, slot, fill_count, one pad bit
    localparam int S_TDATA_W = 88;
    // master tdata: word_out, level, four pad bits
    localparam int M_TDATA_W = 80;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH    = 3'd0,
        CMD_POP     = 3'd1,
        CMD_RESERVE = 3'd2,
        CMD_GET     = 3'd3,
        CMD_SET     = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_BAD_INDEX = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_FILL
    } t_state;

endpackage : vsf_pkg
`default_nettype wire

>>> hw/rtl/vsf_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vsf_mem
// Stack word store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module vsf_mem
    import vsf_pkg::*;
#(
    parameter int DEPTH  = DEF_STACK_DEPTH,
    parameter int ADDR_W = $clog2(DEF_STACK_DEPTH)
) (
    input  wire                i_clk,
    input  wire                i_wr_en,
    input  wire [ADDR_W-1:0]   i_wr_addr,
    input  wire [WORD_W-1:0]   i_wr_data,
    input  wire                i_rd_en,
    input  wire [ADDR_W-1:0]   i_rd_addr,
    output logic [WORD_W-1:0]  o_rd_data
);

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule : vsf_mem
`default_nettype wire

>>> hw/rtl/value_stack_with_frames_core.sv
// Result path: push, set, reserve of zero words and failing commands register
//   their result from the beat; pop and get also pass the memory read and S_READ.
// Throughput: push/set one beat per cycle while the output register is free;
//   none in S_READ or S_FILL; S_FILL zeroes one word per cycle on the write port.
// Reset (i_rst_n low, synchronous): stack empty, no result pending; the word
//   store is not cleared, entries at or above the top are never read.
`default_nettype none
// ----------------------------------------------------------------------------
// value_stack_with_frames_core
// Fixed-depth stack of signed 64-bit words with push, pop, frame reserve and
// indexed get/set. One result beat per command beat.
// ----------------------------------------------------------------------------
module value_stack_with_frames_core
    import vsf_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // command stream
    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire [S_TDATA_W-1:0]    s_axis_tdata,   // word_in[63:0], slot[74:64],
                                                   // fill_count[86:75], pad[87]
    input  wire [CMD_W-1:0]        s_axis_tuser,   // cmd[2:0]
    // result stream
    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    output logic [M_TDATA_W-1:0]   m_axis_tdata,   // word_out[63:0], level[75:64],
                                                   // pad[79:76]
    output logic [STATUS_W-1:0]    m_axis_tuser    // status[1:0]
);

    // Top pointer counts 0..STACK_DEPTH; memory index counts 0..STACK_DEPTH-1.
    localparam int PTR_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);
    // Widths for the reserve bound check and the slot compare.
    localparam int SUM_W  = ((PTR_W > FILL_W) ? PTR_W : FILL_W) + 1;
    localparam int CMP_W  = (PTR_W > SLOT_W) ? PTR_W : SLOT_W;

    // ---------------------------------------------------------------------
    // Input beat fields
    // ---------------------------------------------------------------------
    logic [WORD_W-1:0] in_word;
    logic [SLOT_W-1:0] in_slot;
    logic [FILL_W-1:0] in_fill;
    t_cmd              in_cmd;

    assign in_word = s_axis_tdata[WORD_W-1:0];
    assign in_slot = s_axis_tdata[WORD_W +: SLOT_W];
    assign in_fill = s_axis_tdata[WORD_W+SLOT_W +: FILL_W];
    assign in_cmd  = t_cmd'(s_axis_tuser);

    // ---------------------------------------------------------------------
    // State
    // ---------------------------------------------------------------------
    t_state             r_state, n_state;
    logic [PTR_W-1:0]   r_top, n_top;
    logic [FILL_W-1:0]  r_fill_left, n_fill_left;   // words still to zero

    // Output register: parts the result side from the command side.
    logic               r_out_valid, n_out_valid;
    logic [WORD_W-1:0]  r_out_word, n_out_word;
    logic [LEVEL_W-1:0] r_out_level, n_out_level;
    t_status            r_out_status, n_out_status;

    // Memory port
    logic               mem_wr_en;
    logic [ADDR_W-1:0]  mem_wr_addr;
    logic [WORD_W-1:0]  mem_wr_data;
    logic               mem_rd_en;
    logic [ADDR_W-1:0]  mem_rd_addr;
    logic [WORD_W-1:0]  mem_rd_data;

    // ---------------------------------------------------------------------
    // Checks on the incoming command
    // ---------------------------------------------------------------------
    logic               out_free;
    logic               accept;
    logic               is_full;
    logic               is_empty;
    logic               slot_bad;
    logic               fill_over;
    logic [PTR_W-1:0]   top_dec;
    logic [PTR_W-1:0]   top_inc;

    // Output slot frees up this cycle if empty or being drained.
    assign out_free  = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && out_free;
    assign accept    = s_axis_tvalid && s_axis_tready;

    assign is_full   = (r_top == PTR_W'(STACK_DEPTH));
    assign is_empty  = (r_top == '0);
    assign slot_bad  = (CMP_W'(in_slot) >= CMP_W'(r_top));
    assign fill_over = ((SUM_W'(r_top) + SUM_W'(in_fill)) > SUM_W'(STACK_DEPTH));
    assign top_dec   = r_top - PTR_W'(1);
    assign top_inc   = r_top + PTR_W'(1);

    // ---------------------------------------------------------------------
    // Next state and datapath control
    // ---------------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_top        = r_top;
        n_fill_left  = r_fill_left;

        // result leaves when taken; payload holds
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_word   = r_out_word;
        n_out_level  = r_out_level;
        n_out_status = r_out_status;

        mem_wr_en    = 1'b0;
        mem_wr_addr  = r_top[ADDR_W-1:0];
        mem_wr_data  = in_word;
        mem_rd_en    = 1'b0;
        mem_rd_addr  = ADDR_W'(in_slot);

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    // default result: no data, level unchanged, ok
                    n_out_valid  = 1'b1;
                    n_out_word   = '0;
                    n_out_level  = LEVEL_W'(r_top);
                    n_out_status = ST_OK;

                    case (in_cmd)
                        CMD_PUSH: begin
                            if (is_full) begin
                                n_out_status = ST_OVERFLOW;
                            end else begin
                                mem_wr_en   = 1'b1;
                                n_top       = top_inc;
                                n_out_level = LEVEL_W'(top_inc);
                            end
                        end
                        CMD_POP: begin
                            if (is_empty) begin
                                n_out_status = ST_UNDERFLOW;
                            end else begin
                                // read the old top; result follows via S_READ
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = top_dec[ADDR_W-1:0];
                                n_top       = top_dec;
                                n_out_valid = 1'b0;
                                n_state     = S_READ;
                            end
                        end
                        CMD_RESERVE: begin
                            if (fill_over) begin
                                n_out_status = ST_OVERFLOW;
                            end else if (in_fill != '0) begin
                                // zero the frame one word a cycle
                                n_fill_left = in_fill;
                                n_out_valid = 1'b0;
                                n_state     = S_FILL;
                            end
                        end
                        CMD_GET: begin
                            if (slot_bad) begin
                                n_out_status = ST_BAD_INDEX;
                            end else begin
                                mem_rd_en   = 1'b1;
                                n_out_valid = 1'b0;
                                n_state     = S_READ;
                            end
                        end
                        CMD_SET: begin
                            if (slot_bad) begin
                                n_out_status = ST_BAD_INDEX;
                            end else begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = ADDR_W'(in_slot);
                            end
                        end
                        default: begin
                            // unused codes: plain ok result
                        end
                    endcase
                end
            end

            S_READ: begin
                // read data is out of the memory; output slot is empty here
                n_out_valid  = 1'b1;
                n_out_word   = mem_rd_data;
                n_out_level  = LEVEL_W'(r_top);
                n_out_status = ST_OK;
                n_state      = S_IDLE;
            end

            S_FILL: begin
                mem_wr_en   = 1'b1;
                mem_wr_data = '0;
                n_top       = top_inc;
                n_fill_left = r_fill_left - FILL_W'(1);
                if (r_fill_left == FILL_W'(1)) begin
                    n_out_valid  = 1'b1;
                    n_out_word   = '0;
                    n_out_level  = LEVEL_W'(top_inc);
                    n_out_status = ST_OK;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_top       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_top       <= n_top;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fill_left  <= n_fill_left;
        r_out_word   <= n_out_word;
        r_out_level  <= n_out_level;
        r_out_status <= n_out_status;
    end

    // ---------------------------------------------------------------------
    // Word store
    // ---------------------------------------------------------------------
    vsf_mem #(
        .DEPTH  (STACK_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    // ---------------------------------------------------------------------
    // Result beat
    // ---------------------------------------------------------------------
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(M_TDATA_W - WORD_W - LEVEL_W)'(0), r_out_level, r_out_word};
    assign m_axis_tuser  = r_out_status;

endmodule : value_stack_with_frames_core
`default_nettype wire

>>> sim/vsf_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vsf_checker
// Scoreboard for the value stack: tracks the stack contents from accepted
// command beats, queues the result each one should produce, and compares
// every result beat field by field against the oldest queued entry.
// ----------------------------------------------------------------------------
module vsf_checker
    import vsf_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cmd_tvalid,
    input  wire                  i_cmd_tready,
    input  wire [S_TDATA_W-1:0]  i_cmd_tdata,   // word_in, slot, fill_count, pad
    input  wire [CMD_W-1:0]      i_cmd_tuser,   // cmd
    input  wire                  i_res_tvalid,
    input  wire                  i_res_tready,
    input  wire [M_TDATA_W-1:0]  i_res_tdata,   // word_out, level, pad
    input  wire [STATUS_W-1:0]   i_res_tuser,   // status
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_depth,
    output int                   o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [WORD_W-1:0]  word;
        logic [LEVEL_W-1:0] level;
        t_status            status;
    } t_stack_result;

    logic [WORD_W-1:0] shadow_words [STACK_DEPTH];
    int unsigned       shadow_top = 0;
    t_stack_result     expected_results [$];
    int                fail_count   = 0;
    int                result_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_results.size();
    assign o_depth      = shadow_top;
    assign o_results    = result_count;

    // Applies one command to the shadow stack and returns the result it gives.
    // A failing command leaves the shadow state untouched.
    function automatic t_stack_result apply_command(input logic [CMD_W-1:0]  cmd,
                                                    input logic [WORD_W-1:0] word,
                                                    input logic [SLOT_W-1:0] slot,
                                                    input logic [FILL_W-1:0] fill);
        t_stack_result res;
        res.word   = '0;
        res.status = ST_OK;
        case (cmd)
            CMD_PUSH: begin
                if (shadow_top >= STACK_DEPTH) begin
                    res.status = ST_OVERFLOW;
                end else begin
                    shadow_words[shadow_top] = word;
                    shadow_top++;
                end
            end
            CMD_POP: begin
                if (shadow_top == 0) begin
                    res.status = ST_UNDERFLOW;
                end else begin
                    shadow_top--;
                    res.word = shadow_words[shadow_top];
                end
            end
            CMD_RESERVE: begin
                // all or nothing: no partial fill on overflow
                if (shadow_top + fill > STACK_DEPTH) begin
                    res.status = ST_OVERFLOW;
                end else begin
                    for (int k = 0; k < fill; k++) shadow_words[shadow_top + k] = '0;
                    shadow_top += fill;
                end
            end
            CMD_GET: begin
                if (slot >= shadow_top) res.status = ST_BAD_INDEX;
                else res.word = shadow_words[slot];
            end
            CMD_SET: begin
                if (slot >= shadow_top) res.status = ST_BAD_INDEX;
                else shadow_words[slot] = word;
            end
            default: ;  // unused codes: no state change, zero data
        endcase
        res.level = LEVEL_W'(shadow_top);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_stack_result want;
        t_stack_result got;
        if (!i_rst_n) begin
            shadow_top = 0;
            expected_results.delete();
        end else begin
            // result side first: a beat here always belongs to an older command
            if (i_res_tvalid && i_res_tready) begin
                result_count++;
                got.word   = i_res_tdata[WORD_W-1:0];
                got.level  = i_res_tdata[WORD_W +: LEVEL_W];
                got.status = t_status'(i_res_tuser);
                if (expected_results.size() == 0) begin
                    fail_count++;
                    $display("%0t ns: unexpected result beat, expected none actual %h",
                             $time, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got.word !== want.word) begin
                        fail_count++;
                        $display("%0t ns: word_out mismatch, expected %h actual %h",
                                 $time, want.word, got.word);
                    end
                    if (got.level !== want.level) begin
                        fail_count++;
                        $display("%0t ns: level mismatch, expected %0d actual %0d",
                                 $time, want.level, got.level);
                    end
                    if (got.status !== want.status) begin
                        fail_count++;
                        $display("%0t ns: status mismatch, expected %0d actual %0d",
                                 $time, want.status, got.status);
                    end
                end
            end
            if (i_cmd_tvalid && i_cmd_tready) begin
                expected_results.push_back(apply_command(i_cmd_tuser,
                                                         i_cmd_tdata[WORD_W-1:0],
                                                         i_cmd_tdata[WORD_W +: SLOT_W],
                                                         i_cmd_tdata[WORD_W+SLOT_W +: FILL_W]));
            end
        end
    end

endmodule : vsf_checker
`default_nettype wire

>>> sim/tb_value_stack_with_frames_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_value_stack_with_frames_core
// Stimulus and verdict for the value stack: directed corner commands, four
// phases of random traffic under different handshake pressure, then a fill
// to the full depth with the overflow corners; checking is in vsf_checker.
// ----------------------------------------------------------------------------
module tb_value_stack_with_frames_core
    import vsf_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH = DEF_STACK_DEPTH;
    // worst quiet stretch is a full-depth reserve plus a stall
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASE_BEATS    = 100;

    localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = 3'd5;
    localparam logic [CMD_W-1:0] CMD_MID_UNUSED   = 3'd6;
    localparam logic [CMD_W-1:0] CMD_LAST_UNUSED  = 3'd7;

    localparam logic [WORD_W-1:0] WORD_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [WORD_W-1:0] WORD_MIN   = 64'h8000_0000_0000_0000;
    localparam logic [WORD_W-1:0] WORD_MINUS = 64'hFFFF_FFFF_FFFF_FFFF;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    wire                   s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [CMD_W-1:0]      s_axis_tuser  = '0;
    wire                   m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    wire  [M_TDATA_W-1:0]  m_axis_tdata;
    wire  [STATUS_W-1:0]   m_axis_tuser;

    int fail_count;
    int pending_results;
    int model_depth;
    int result_beats;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cmd_beats      = 0;
    int quiet_cycles   = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    value_stack_with_frames_core #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    vsf_checker #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_tvalid (s_axis_tvalid),
        .i_cmd_tready (s_axis_tready),
        .i_cmd_tdata  (s_axis_tdata),
        .i_cmd_tuser  (s_axis_tuser),
        .i_res_tvalid (m_axis_tvalid),
        .i_res_tready (m_axis_tready),
        .i_res_tdata  (m_axis_tdata),
        .i_res_tuser  (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending_results),
        .o_depth      (model_depth),
        .o_results    (result_beats)
    );

    // receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        if (!i_rst_n) m_axis_tready <= 1'b0;
        else m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog: cycles with no beat on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog expired after %0d quiet cycles", quiet_cycles);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // One command beat; optional idle cycles first, then held while tready is low.
    // tvalid stays high into the next call so back-to-back beats have no gap.
    task automatic send_cmd(input logic [CMD_W-1:0]  cmd,
                            input logic [WORD_W-1:0] word,
                            input logic [SLOT_W-1:0] slot,
                            input logic [FILL_W-1:0] fill);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {1'b0, fill, slot, word};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        cmd_beats++;
    endtask

    // sender pauses until every queued result has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // Mostly legal traffic steered by the current depth, plus some noise.
    task automatic random_cmd();
        int                pick;
        int                depth;
        logic [CMD_W-1:0]  cmd;
        logic [WORD_W-1:0] word;
        logic [SLOT_W-1:0] slot;
        logic [FILL_W-1:0] fill;
        pick  = $urandom_range(99);
        depth = model_depth;
        case ($urandom_range(9))
            0:       word = WORD_MAX;
            1:       word = WORD_MIN;
            2:       word = WORD_MINUS;
            default: word = {$urandom, $urandom};
        endcase
        // index mostly below the top, sometimes anywhere
        if (depth > 0 && $urandom_range(99) < 85) slot = SLOT_W'($urandom_range(depth - 1));
        else slot = SLOT_W'($urandom_range(STACK_DEPTH - 1));
        fill = FILL_W'($urandom_range(8));
        if (pick < 22) begin
            cmd = CMD_PUSH;
        end else if (pick < 50) begin
            cmd = CMD_POP;
        end else if (pick < 58) begin
            cmd = CMD_RESERVE;
            if ($urandom_range(49) == 0) fill = FILL_W'($urandom_range(STACK_DEPTH));
        end else if (pick < 76) begin
            cmd = CMD_GET;
        end else if (pick < 94) begin
            cmd = CMD_SET;
        end else begin
            cmd = CMD_W'($urandom_range(CMD_LAST_UNUSED, CMD_FIRST_UNUSED));
        end
        send_cmd(cmd, word, slot, fill);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty-stack errors, extremes, frame, unused codes
        send_cmd(CMD_POP,     '0,         '0,    '0);
        send_cmd(CMD_GET,     '0,         '0,    '0);
        send_cmd(CMD_SET,     WORD_MAX,   11'h7FF, '0);
        send_cmd(CMD_RESERVE, '0,         '0,    12'd0);
        send_cmd(CMD_PUSH,    WORD_MAX,   '0,    '0);
        send_cmd(CMD_PUSH,    WORD_MIN,   '0,    '0);
        send_cmd(CMD_PUSH,    WORD_MINUS, '0,    '0);
        send_cmd(CMD_RESERVE, '0,         '0,    12'd3);
        send_cmd(CMD_GET,     '0,         11'd0, '0);
        send_cmd(CMD_GET,     '0,         11'd5, '0);
        send_cmd(CMD_GET,     '0,         11'd6, '0);
        send_cmd(CMD_SET,     64'h0123_4567_89AB_CDEF, 11'd4, '0);
        send_cmd(CMD_GET,     '0,         11'd4, '0);
        send_cmd(CMD_FIRST_UNUSED,   WORD_MINUS, 11'h7FF, 12'hFFF);
        send_cmd(CMD_MID_UNUSED,     WORD_MAX,   11'h2AA, 12'h555);
        send_cmd(CMD_LAST_UNUSED,    WORD_MIN,   11'h555, 12'hAAA);
        send_cmd(CMD_RESERVE, '0,         '0,    12'd2048);
        send_cmd(CMD_POP,     '0,         '0,    '0);
        send_cmd(CMD_POP,     '0,         '0,    '0);
        send_cmd(CMD_POP,     '0,         '0,    '0);
        drain_results();

        // random traffic under four pressure settings
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            repeat (PHASE_BEATS) random_cmd();
            drain_results();
        end

        // fill exactly to the depth, then the full-stack corners
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_cmd(CMD_RESERVE, '0,       '0,      FILL_W'(STACK_DEPTH - model_depth));
        send_cmd(CMD_PUSH,    WORD_MAX, '0,      '0);
        send_cmd(CMD_RESERVE, '0,       '0,      12'd1);
        send_cmd(CMD_RESERVE, '0,       '0,      12'd0);
        send_cmd(CMD_RESERVE, '0,       '0,      12'd2048);
        send_cmd(CMD_SET,     WORD_MIN, 11'h7FF, '0);
        send_cmd(CMD_GET,     '0,       11'h7FF, '0);
        send_cmd(CMD_POP,     '0,       '0,      '0);
        send_cmd(CMD_RESERVE, '0,       '0,      12'd2);
        send_cmd(CMD_RESERVE, '0,       '0,      12'd1);
        drain_results();
        repeat (8) @(posedge i_clk);

        $display("Ran %0d command beats and checked %0d result beats: empty and full stack,",
                 cmd_beats, result_beats);
        $display("frame reserves, indexed get/set, unused codes, idle and stall phases.");
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("Verification failed");
        end
        $finish;
    end

endmodule : tb_value_stack_with_frames_core
`default_nettype wire

>>> value_stack_with_frames_core.f
hw/rtl/vsf_pkg.sv
hw/rtl/vsf_mem.sv
hw/rtl/value_stack_with_frames_core.sv
sim/vsf_checker.sv
sim/tb_value_stack_with_frames_core.sv
